### hdl/hba_pkg.sv
// shared types and constants for the histogram bin remap accumulator
// no dependencies; hba_map and the top level use scoped names, the testbench imports it
package hba_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_DEST_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_MIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_BINS = 3'd4;

    // mapping datapath widths
    localparam int PROD_W = 52;   // 34 x 18 signed product
    localparam int P_W    = 49;   // config products, signed
    localparam int PB_W   = 48;   // destination span times source step
    localparam int A_W    = 51;   // signed offset into the destination range
    localparam int MAG_W  = 50;   // magnitude of that offset
    localparam int SC_W   = 41;   // half magnitude times bin scale
    localparam int DIV_W  = 68;   // rounding divider numerator
    localparam int STEP_W = 5;    // step counter of the mapping unit

    typedef enum logic [1:0] {
        MODE_ADD,
        MODE_SUB,
        MODE_QUERY,
        MODE_SCALE
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic [15:0]        src_bin;
        logic signed [63:0] src_count;
        logic signed [31:0] sample_value;
        logic signed [63:0] factor;
    } t_in;

    typedef struct packed {
        logic signed [63:0] bin_count;
        logic [7:0]         dest_bin;
        logic               in_range;
        logic signed [63:0] total_count;
    } t_out;

    typedef struct packed {
        logic signed [31:0] dest_min;
        logic signed [31:0] dest_max;
        logic signed [31:0] src_min;
        logic signed [31:0] src_max;
        logic [16:0]        src_bins;
    } t_cfg;

    typedef struct packed {
        logic done;
        logic hit;
    } t_map_res;

    typedef enum logic [2:0] {
        MAP_IDLE,
        MAP_PROD,
        MAP_SUM,
        MAP_SCALE,
        MAP_NUM,
        MAP_CHK,
        MAP_DIV,
        MAP_DONE
    } t_map_state;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAP,
        ST_READ,
        ST_MODIFY,
        ST_SCALE_READ,
        ST_SCALE_START,
        ST_SCALE_MUL,
        ST_TOTAL_START,
        ST_TOTAL_MUL,
        ST_DONE
    } t_top_state;

endpackage

### hdl/hba_bin_mem.sv
// bin count storage: one write port, one read port with registered data
// depends on nothing but its parameters
module hba_bin_mem #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [63:0]       i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [63:0]       o_rdata
);

    logic [63:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered data
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### hdl/hba_mul64.sv
// 64 x 64 multiplier, low 64 bits, built from one shared 32 x 32 unit over 3 steps
// depends on nothing; product is valid in the cycle o_done is high
module hba_mul64 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic [63:0] o_prod
);

    logic        r_busy;
    logic [1:0]  r_step;
    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [63:0] r_acc;
    logic [31:0] r_cross;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    // operand select for the partial products
    always_comb begin
        case (r_step)
            2'd0: begin
                mul_a = r_a[31:0];
                mul_b = r_b[31:0];
            end
            2'd1: begin
                mul_a = r_a[31:0];
                mul_b = r_b[63:32];
            end
            2'd2: begin
                mul_a = r_a[63:32];
                mul_b = r_b[31:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // sequencing control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 2'd1;
            if (r_step == 2'd3) begin
                r_busy <= 1'b0;
            end
        end
    end

    // partial product accumulation
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end else if (r_busy) begin
            case (r_step)
                2'd0: r_acc <= mul_p;
                2'd1: r_cross <= mul_p[31:0];
                2'd2: r_cross <= r_cross + mul_p[31:0];
                default: ;
            endcase
        end
    end

    assign o_done = r_busy && (r_step == 2'd3);
    assign o_prod = r_acc + {r_cross, 32'b0};

endmodule

### hdl/hba_map.sv
// maps a source bin or a sample value to a destination bin with one final rounding
// depends on hba_pkg; one shared 34 x 18 multiplier and a bit-per-cycle divider
module hba_map #(
    parameter int NUM_BINS = 256,
    parameter int BIN_W    = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_query,
    input  hba_pkg::t_cfg      i_cfg,
    input  logic [15:0]        i_src_bin,
    input  logic signed [31:0] i_sample,
    output hba_pkg::t_map_res  o_res,
    output logic [BIN_W-1:0]   o_bin
);

    localparam logic [15:0] M_FULL = 16'(NUM_BINS - 1);

    hba_pkg::t_map_state r_state;
    hba_pkg::t_map_state n_state;

    logic [hba_pkg::STEP_W-1:0]      r_step;
    logic signed [hba_pkg::P_W-1:0]  r_p0;
    logic signed [hba_pkg::P_W-1:0]  r_p1;
    logic signed [hba_pkg::P_W-1:0]  r_p2;
    logic [hba_pkg::PB_W-1:0]        r_p3;
    logic [hba_pkg::SC_W-1:0]        r_plo;
    logic [hba_pkg::SC_W-1:0]        r_phi;
    logic [hba_pkg::MAG_W-1:0]       r_mag;
    logic [hba_pkg::PB_W-1:0]        r_b;
    logic [15:0]                     r_m;
    logic                            r_neg;
    logic                            r_skip;
    logic                            r_ovf;
    logic [hba_pkg::DIV_W-1:0]       r_rem;
    logic [hba_pkg::DIV_W-1:0]       r_div;
    logic [hba_pkg::DIV_W-1:0]       r_dsh;
    logic [BIN_W-1:0]                r_q;

    logic signed [31:0] smin, smax, dmin, dmax;
    logic signed [32:0] sspan, dspan;
    logic               src_narrow, dest_narrow, skip;
    logic [16:0]        rden;

    logic signed [33:0]                op_a;
    logic signed [17:0]                op_b;
    logic signed [hba_pkg::PROD_W-1:0] prod;

    logic signed [hba_pkg::A_W-1:0] rnum, a_val, abs_a;
    logic [hba_pkg::PB_W-1:0]       b_val;
    logic [15:0]                    m_val;
    logic [hba_pkg::DIV_W-1:0]      num_w;
    logic                           rem_ge;

    // range decode from the configuration
    always_comb begin
        smin        = i_cfg.src_min;
        smax        = i_cfg.src_max;
        dmin        = i_cfg.dest_min;
        dmax        = i_cfg.dest_max;
        sspan       = $signed({smax[31], smax}) - $signed({smin[31], smin});
        dspan       = $signed({dmax[31], dmax}) - $signed({dmin[31], dmin});
        src_narrow  = (i_cfg.src_bins < 17'd2) || !(smax > smin);
        rden        = src_narrow ? 17'd1 : i_cfg.src_bins - 17'd1;
        dest_narrow = !(dmax > dmin);
        if (i_query) begin
            skip = dest_narrow;
        end else begin
            skip = ({1'b0, i_src_bin} >= i_cfg.src_bins) || (smin > smax) || (dmin > dmax);
        end
    end

    // shared multiplier operand select
    always_comb begin
        op_a = '0;
        op_b = '0;
        if (r_state == hba_pkg::MAP_PROD) begin
            case (r_step[1:0])
                2'd0: begin
                    op_a = {{2{smin[31]}}, smin};
                    op_b = {1'b0, rden};
                end
                2'd1: begin
                    op_a = {{2{dmin[31]}}, dmin};
                    op_b = {1'b0, rden};
                end
                2'd2: begin
                    op_a = {sspan[32], sspan};
                    op_b = {2'b0, i_src_bin};
                end
                default: begin
                    op_a = {dspan[32], dspan};
                    op_b = {1'b0, rden};
                end
            endcase
        end else if (r_state == hba_pkg::MAP_SCALE) begin
            if (r_step[0]) begin
                op_a = {9'b0, r_mag[49:25]};
            end else begin
                op_a = {9'b0, r_mag[24:0]};
            end
            op_b = {2'b0, r_m};
        end
    end

    assign prod = op_a * op_b;

    // offset, span and scale of the mapping
    always_comb begin
        if (src_narrow) begin
            rnum = $signed({19'b0, i_src_bin, 16'b0});
        end else begin
            rnum = $signed({{2{r_p0[48]}}, r_p0}) + $signed({{2{r_p2[48]}}, r_p2});
        end
        if (i_query) begin
            a_val = $signed({{19{i_sample[31]}}, i_sample}) - $signed({{19{dmin[31]}}, dmin});
            b_val = {15'b0, dspan};
            m_val = M_FULL;
        end else if (dest_narrow) begin
            a_val = rnum;
            b_val = {15'b0, rden, 16'b0};
            m_val = 16'd1;
        end else begin
            a_val = rnum - $signed({{2{r_p1[48]}}, r_p1});
            b_val = r_p3;
            m_val = M_FULL;
        end
        abs_a = a_val[hba_pkg::A_W-1] ? -a_val : a_val;
    end

    // numerator for round half up: 2*m*mag + b over 2*b
    assign num_w  = hba_pkg::DIV_W'({r_phi, 25'b0}) + hba_pkg::DIV_W'(r_plo);
    assign rem_ge = r_rem >= r_dsh;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hba_pkg::MAP_IDLE:  if (i_start) n_state = hba_pkg::MAP_PROD;
            hba_pkg::MAP_PROD:  if (r_step[1:0] == 2'd3) n_state = hba_pkg::MAP_SUM;
            hba_pkg::MAP_SUM:   n_state = hba_pkg::MAP_SCALE;
            hba_pkg::MAP_SCALE: if (r_step[0]) n_state = hba_pkg::MAP_NUM;
            hba_pkg::MAP_NUM:   n_state = hba_pkg::MAP_CHK;
            hba_pkg::MAP_CHK:   n_state = hba_pkg::MAP_DIV;
            hba_pkg::MAP_DIV:   if (r_step == '0) n_state = hba_pkg::MAP_DONE;
            hba_pkg::MAP_DONE:  n_state = hba_pkg::MAP_IDLE;
            default:            n_state = hba_pkg::MAP_IDLE;
        endcase
    end

    // state and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hba_pkg::MAP_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            case (r_state) inside
                hba_pkg::MAP_PROD,
                hba_pkg::MAP_SCALE: r_step <= (n_state == r_state) ? r_step + 1'b1 : '0;
                hba_pkg::MAP_CHK:   r_step <= hba_pkg::STEP_W'(BIN_W - 1);
                hba_pkg::MAP_DIV:   r_step <= r_step - 1'b1;
                default:            r_step <= '0;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            hba_pkg::MAP_PROD: begin
                case (r_step[1:0])
                    2'd0:    r_p0 <= prod[hba_pkg::P_W-1:0];
                    2'd1:    r_p1 <= prod[hba_pkg::P_W-1:0];
                    2'd2:    r_p2 <= prod[hba_pkg::P_W-1:0];
                    default: r_p3 <= prod[hba_pkg::PB_W-1:0];
                endcase
            end
            hba_pkg::MAP_SUM: begin
                r_mag  <= abs_a[hba_pkg::MAG_W-1:0];
                r_neg  <= a_val[hba_pkg::A_W-1];
                r_b    <= b_val;
                r_m    <= m_val;
                r_skip <= skip;
            end
            hba_pkg::MAP_SCALE: begin
                if (r_step[0]) begin
                    r_phi <= prod[hba_pkg::SC_W-1:0];
                end else begin
                    r_plo <= prod[hba_pkg::SC_W-1:0];
                end
            end
            hba_pkg::MAP_NUM: begin
                r_rem <= (num_w << 1) + hba_pkg::DIV_W'(r_b);
                r_div <= hba_pkg::DIV_W'({r_b, 1'b0});
            end
            hba_pkg::MAP_CHK: begin
                r_ovf <= r_rem >= (r_div << BIN_W);
                r_dsh <= r_div << (BIN_W - 1);
                r_q   <= '0;
            end
            hba_pkg::MAP_DIV: begin
                if (rem_ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_q   <= BIN_W'({r_q, rem_ge});
                r_dsh <= r_dsh >> 1;
            end
            default: ;
        endcase
    end

    // result: negative offsets only land in bin zero when they round to it
    always_comb begin
        o_res.done = (r_state == hba_pkg::MAP_DONE);
        o_res.hit  = !r_skip && !r_ovf &&
                     (r_neg ? (r_q == '0) : ({1'b0, r_q} < (BIN_W + 1)'(NUM_BINS)));
        o_bin      = r_q;
    end

endmodule

### hdl/histogram_bin_remap_accumulator.sv
// Histogram of NUM_BINS signed 64-bit counts, held in one synchronous memory, with
// a running total in a register. After reset the memory is swept to zero bin by
// bin with the request port held off. A merge or query passes through the mapping
// unit (four config products on one multiplier, two scale products, then one
// quotient bit per cycle), then the hit bin is read and, for a merge, written back;
// a miss skips the bin access. A multiply reads each bin, passes it through a
// 64-bit multiplier built from three 32 x 32 steps and writes it back, then scales
// the total. The request port is ready again in the cycle after the result
// register has been loaded.
// Top level; depends on hba_pkg, hba_map, hba_mul64 and hba_bin_mem
module histogram_bin_remap_accumulator #(
    parameter int NUM_BINS = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  hba_pkg::t_in                     i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output hba_pkg::t_out                    o_out,
    input  logic                             i_cfg_we,
    input  logic [hba_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [hba_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

    hba_pkg::t_top_state r_state;
    hba_pkg::t_top_state n_state;

    hba_pkg::t_cfg     r_cfg;
    hba_pkg::t_in      r_item;
    hba_pkg::t_out     r_res;
    hba_pkg::t_out     r_out;
    logic              r_out_valid;
    logic [63:0]       r_total;
    logic [BIN_W-1:0]  r_idx;
    logic [BIN_W-1:0]  r_bin;

    logic              accept;
    logic              out_free;
    logic              is_merge;
    hba_pkg::t_map_res map_res;
    logic [BIN_W-1:0]  map_bin;
    logic              map_start;
    logic              mul_start;
    logic              mul_done;
    logic [63:0]       mul_a;
    logic [63:0]       mul_prod;
    logic              mem_we;
    logic [BIN_W-1:0]  mem_waddr;
    logic [BIN_W-1:0]  mem_raddr;
    logic [63:0]       mem_wdata;
    logic [63:0]       mem_rdata;
    logic [63:0]       mod_val;
    logic [63:0]       mod_total;

    assign accept    = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;
    assign is_merge  = (r_item.mode == hba_pkg::MODE_ADD) || (r_item.mode == hba_pkg::MODE_SUB);
    assign map_start = accept && (i_in.mode != hba_pkg::MODE_SCALE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dest_min <= 32'sd0;
            r_cfg.dest_max <= 32'sd16711680;
            r_cfg.src_min  <= 32'sd0;
            r_cfg.src_max  <= 32'sd16711680;
            r_cfg.src_bins <= 17'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                hba_pkg::CFG_DEST_MIN: r_cfg.dest_min <= $signed(i_cfg_data);
                hba_pkg::CFG_DEST_MAX: r_cfg.dest_max <= $signed(i_cfg_data);
                hba_pkg::CFG_SRC_MIN:  r_cfg.src_min  <= $signed(i_cfg_data);
                hba_pkg::CFG_SRC_MAX:  r_cfg.src_max  <= $signed(i_cfg_data);
                hba_pkg::CFG_SRC_BINS: r_cfg.src_bins <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    hba_map #(
        .NUM_BINS (NUM_BINS),
        .BIN_W    (BIN_W)
    ) u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (map_start),
        .i_query   (r_item.mode == hba_pkg::MODE_QUERY),
        .i_cfg     (r_cfg),
        .i_src_bin (r_item.src_bin),
        .i_sample  (r_item.sample_value),
        .o_res     (map_res),
        .o_bin     (map_bin)
    );

    hba_mul64 u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (r_item.factor),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    hba_bin_mem #(
        .DEPTH  (NUM_BINS),
        .ADDR_W (BIN_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // merge arithmetic, wrapping
    always_comb begin
        if (r_item.mode == hba_pkg::MODE_SUB) begin
            mod_val   = mem_rdata - r_item.src_count;
            mod_total = r_total - r_item.src_count;
        end else begin
            mod_val   = mem_rdata + r_item.src_count;
            mod_total = r_total + r_item.src_count;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hba_pkg::ST_CLEAR: begin
                if (r_idx == LAST_BIN) n_state = hba_pkg::ST_IDLE;
            end
            hba_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = (i_in.mode == hba_pkg::MODE_SCALE) ?
                              hba_pkg::ST_SCALE_READ : hba_pkg::ST_MAP;
                end
            end
            hba_pkg::ST_MAP: begin
                if (map_res.done) begin
                    n_state = map_res.hit ? hba_pkg::ST_READ : hba_pkg::ST_DONE;
                end
            end
            hba_pkg::ST_READ:        n_state = hba_pkg::ST_MODIFY;
            hba_pkg::ST_MODIFY:      n_state = hba_pkg::ST_DONE;
            hba_pkg::ST_SCALE_READ:  n_state = hba_pkg::ST_SCALE_START;
            hba_pkg::ST_SCALE_START: n_state = hba_pkg::ST_SCALE_MUL;
            hba_pkg::ST_SCALE_MUL: begin
                if (mul_done) begin
                    n_state = (r_idx == LAST_BIN) ?
                              hba_pkg::ST_TOTAL_START : hba_pkg::ST_SCALE_READ;
                end
            end
            hba_pkg::ST_TOTAL_START: n_state = hba_pkg::ST_TOTAL_MUL;
            hba_pkg::ST_TOTAL_MUL: begin
                if (mul_done) n_state = hba_pkg::ST_DONE;
            end
            hba_pkg::ST_DONE: begin
                if (out_free) n_state = hba_pkg::ST_IDLE;
            end
            default: n_state = hba_pkg::ST_IDLE;
        endcase
    end

    // control outputs: handshake, memory ports, multiplier start
    always_comb begin
        o_in_ready = (r_state == hba_pkg::ST_IDLE);
        mem_we     = 1'b0;
        mem_waddr  = r_idx;
        mem_wdata  = '0;
        mem_raddr  = (r_state == hba_pkg::ST_SCALE_READ) ? r_idx : r_bin;
        mul_start  = (r_state == hba_pkg::ST_SCALE_START) ||
                     (r_state == hba_pkg::ST_TOTAL_START);
        mul_a      = (r_state == hba_pkg::ST_TOTAL_START) ? r_total : mem_rdata;
        unique case (r_state)
            hba_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
            end
            hba_pkg::ST_MODIFY: begin
                mem_we    = is_merge;
                mem_waddr = r_bin;
                mem_wdata = mod_val;
            end
            hba_pkg::ST_SCALE_MUL: begin
                mem_we    = mul_done;
                mem_wdata = mul_prod;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hba_pkg::ST_CLEAR;
            r_idx       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                hba_pkg::ST_CLEAR:     r_idx <= r_idx + 1'b1;
                hba_pkg::ST_IDLE:      r_idx <= '0;
                hba_pkg::ST_SCALE_MUL: if (mul_done) r_idx <= r_idx + 1'b1;
                default: ;
            endcase
            if ((r_state == hba_pkg::ST_MODIFY) && is_merge) begin
                r_total <= mod_total;
            end else if ((r_state == hba_pkg::ST_TOTAL_MUL) && mul_done) begin
                r_total <= mul_prod;
            end
            if ((r_state == hba_pkg::ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in;
        end
        if ((r_state == hba_pkg::ST_MAP) && map_res.done) begin
            r_bin <= map_bin;
            r_res <= '{bin_count: '0, dest_bin: '0, in_range: 1'b0, total_count: r_total};
        end
        if (r_state == hba_pkg::ST_MODIFY) begin
            r_res.bin_count   <= is_merge ? mod_val : mem_rdata;
            r_res.dest_bin    <= 8'({8'b0, r_bin});
            r_res.in_range    <= 1'b1;
            r_res.total_count <= is_merge ? mod_total : r_total;
        end
        if ((r_state == hba_pkg::ST_TOTAL_MUL) && mul_done) begin
            r_res <= '{bin_count: '0, dest_bin: '0, in_range: 1'b0, total_count: mul_prod};
        end
        if ((r_state == hba_pkg::ST_DONE) && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // mapping unit only reports while the sequencer waits for it
    a_map_done_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        map_res.done |-> (r_state == hba_pkg::ST_MAP))
        else $error("mapping result outside map wait");

    // multiplier only completes while a scale step waits for it
    a_mul_done_in_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> ((r_state == hba_pkg::ST_SCALE_MUL) || (r_state == hba_pkg::ST_TOTAL_MUL)))
        else $error("multiplier result outside scale wait");

    // one request at a time
    a_single_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready)
        else $error("request taken while another is in progress");

    // a finished result reaches the output register when it is free
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == hba_pkg::ST_DONE) && !r_out_valid) |=> o_out_valid)
        else $error("finished result not presented");

endmodule

### tb/tb_top.sv
// self-checking testbench for histogram_bin_remap_accumulator
// keeps its own copy of the bin store and checks every result in order
// depends on hba_pkg and the block's RTL
`timescale 1ns / 100ps

module tb_top;
    import hba_pkg::*;

    localparam int NBINS      = 256;
    localparam int IDLE_LIMIT = 20000;
    localparam int PHASES     = 8;
    localparam int PER_PHASE  = 166;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in         in_req;
    logic        out_valid;
    logic        out_ready;
    t_out        out_res;
    logic        cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    histogram_bin_remap_accumulator #(.NUM_BINS(NBINS)) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_res),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_data  (cfg_data)
    );

    // model state and configuration copy, counts start at zero
    longint unsigned bin_counts[NBINS];
    longint unsigned sum_count;
    t_cfg            cfg_copy;

    t_in   req_fifo[$];
    t_out  due_results[$];
    int    fail_cnt;
    int    send_idle;
    int    recv_stall;
    int    quiet_cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // round_half_away(m * a / b) into a bin, true if inside the store
    function automatic bit map_to_bin(input longint a, input longint unsigned b,
                                      input longint unsigned m, output int unsigned bin);
        bit              neg;
        longint unsigned mag, q0, r, qq, rr, tot;
        neg = a < 0;
        mag = neg ? 64'(-a) : 64'(a);
        q0  = mag / b;
        r   = mag % b;
        qq  = 0;
        rr  = 0;
        bin = 0;
        if (q0 > NBINS) return 0;
        for (int i = 31; i >= 0; i--) begin
            qq = qq << 1;
            rr = rr << 1;
            if (rr >= b) begin rr -= b; qq++; end
            if (m[i]) begin
                rr += r;
                if (rr >= b) begin rr -= b; qq++; end
            end
        end
        tot = m * q0 + qq;
        if (2 * rr >= b) tot++;
        if (neg) return tot == 0;
        if (tot >= NBINS) return 0;
        bin = int'(tot);
        return 1;
    endfunction

    function automatic bit merge_bin(input logic [15:0] sbin, output int unsigned bin);
        longint smin, smax, dmin, dmax, nbins, x, rnum, rden;
        smin  = longint'(cfg_copy.src_min);
        smax  = longint'(cfg_copy.src_max);
        dmin  = longint'(cfg_copy.dest_min);
        dmax  = longint'(cfg_copy.dest_max);
        nbins = longint'({47'd0, cfg_copy.src_bins});
        x     = longint'({48'd0, sbin});
        bin   = 0;
        if (x >= nbins || smin > smax || dmin > dmax) return 0;
        if (nbins >= 2 && smax > smin) begin
            rden = nbins - 1;
            rnum = smin * rden + (smax - smin) * x;
        end else begin
            rden = 1;
            rnum = x * 65536;
        end
        if (dmax > dmin)
            return map_to_bin(rnum - dmin * rden, 64'((dmax - dmin) * rden), NBINS - 1, bin);
        return map_to_bin(rnum, 64'(65536 * rden), 1, bin);
    endfunction

    // update the bin store for one accepted request and queue its result
    function automatic void apply_request(input t_in req);
        int unsigned bin;
        bit          hit;
        longint      dmin, dmax;
        t_out        res;
        hit = 0;
        bin = 0;
        case (req.mode) inside
            MODE_ADD, MODE_SUB: begin
                hit = merge_bin(req.src_bin, bin);
                if (hit && req.mode == MODE_ADD) begin
                    bin_counts[bin] += req.src_count;
                    sum_count       += req.src_count;
                end else if (hit) begin
                    bin_counts[bin] -= req.src_count;
                    sum_count       -= req.src_count;
                end
            end
            MODE_QUERY: begin
                dmin = longint'(cfg_copy.dest_min);
                dmax = longint'(cfg_copy.dest_max);
                if (dmax > dmin)
                    hit = map_to_bin(longint'(req.sample_value) - dmin, 64'(dmax - dmin),
                                     NBINS - 1, bin);
            end
            default: begin
                for (int i = 0; i < NBINS; i++) bin_counts[i] *= req.factor;
                sum_count *= req.factor;
            end
        endcase
        res.bin_count   = hit ? bin_counts[bin] : 64'd0;
        res.dest_bin    = hit ? bin[7:0] : 8'd0;
        res.in_range    = hit;
        res.total_count = sum_count;
        due_results.push_back(res);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        fail_cnt++;
    endtask

    function automatic t_in make_req(input t_mode m, input logic [15:0] sbin,
                                     input logic [63:0] cnt, input logic [31:0] sv,
                                     input logic [63:0] f);
        t_in r;
        r.mode         = m;
        r.src_bin      = sbin;
        r.src_count    = cnt;
        r.sample_value = sv;
        r.factor       = f;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // random request, mostly aimed at bins that exist under the current setting
    function automatic t_in random_req();
        t_in    r;
        int     pick;
        longint dmin, span;
        r    = make_req(MODE_ADD, 16'($urandom), rand64(), $urandom, rand64());
        pick = $urandom_range(99);
        if (pick < 42)      r.mode = MODE_ADD;
        else if (pick < 64) r.mode = MODE_SUB;
        else if (pick < 96) r.mode = MODE_QUERY;
        else                r.mode = MODE_SCALE;
        if ($urandom_range(9) < 8 && cfg_copy.src_bins != 0)
            r.src_bin = 16'($urandom_range(int'(cfg_copy.src_bins) - 1));
        if ($urandom_range(9) < 7)
            r.src_count = longint'($signed($urandom_range(2000))) - 1000;
        dmin = longint'(cfg_copy.dest_min);
        span = longint'(cfg_copy.dest_max) - dmin;
        if ($urandom_range(9) < 8 && span > 0)
            r.sample_value = 32'(dmin + longint'(rand64() % 64'(span + 1)));
        if ($urandom_range(9) < 8)
            r.factor = longint'($urandom_range(6)) - 3;
        return r;
    endfunction

    task automatic write_cfg(input logic [31:0] dmin, input logic [31:0] dmax,
                             input logic [31:0] smin, input logic [31:0] smax,
                             input logic [16:0] nbins);
        logic [31:0] vals[5];
        vals = '{dmin, dmax, smin, smax, {15'd0, nbins}};
        for (int i = 0; i < 5; i++) begin
            @(posedge i_clk);
            cfg_we   <= 1'b1;
            cfg_addr <= CFG_IDX_W'(i);
            cfg_data <= vals[i];
        end
        @(posedge i_clk);
        cfg_we <= 1'b0;
        cfg_copy.dest_min = dmin;
        cfg_copy.dest_max = dmax;
        cfg_copy.src_min  = smin;
        cfg_copy.src_max  = smax;
        cfg_copy.src_bins = nbins;
    endtask

    task automatic drain();
        while (req_fifo.size() != 0 || in_valid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (in_valid) apply_request(in_req);
            if (req_fifo.size() != 0 && $urandom_range(99) >= send_idle) begin
                in_req   <= req_fifo.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (due_results.size() == 0) begin
                    report_mismatch("unexpected result", out_res.total_count, 64'd0);
                end else begin
                    want = due_results.pop_front();
                    if (out_res.bin_count !== want.bin_count)
                        report_mismatch("bin_count", out_res.bin_count, want.bin_count);
                    if (out_res.dest_bin !== want.dest_bin)
                        report_mismatch("dest_bin", 64'(out_res.dest_bin), 64'(want.dest_bin));
                    if (out_res.in_range !== want.in_range)
                        report_mismatch("in_range", 64'(out_res.in_range), 64'(want.in_range));
                    if (out_res.total_count !== want.total_count)
                        report_mismatch("total_count", out_res.total_count,
                                        want.total_count);
                end
            end
            out_ready <= $urandom_range(99) >= recv_stall;
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("histogram_bin_remap_accumulator test failed");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        i_rst_n    = 1'b0;
        cfg_we     = 1'b0;
        cfg_addr   = '0;
        cfg_data   = '0;
        send_idle  = 0;
        recv_stall = 0;
        cfg_copy = '{dest_min: 0, dest_max: 32'd16711680, src_min: 0,
                     src_max: 32'd16711680, src_bins: 17'd256};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, every mode, skipped and missed bins
        req_fifo.push_back(make_req(MODE_ADD, 16'd0, 64'h7fff_ffff_ffff_ffff, 0, 0));
        req_fifo.push_back(make_req(MODE_ADD, 16'd255, 64'h8000_0000_0000_0000, 0, 0));
        req_fifo.push_back(make_req(MODE_SUB, 16'd17, 64'hffff_ffff_ffff_ffff, 0, 0));
        req_fifo.push_back(make_req(MODE_ADD, 16'd256, 64'd5, 0, 0));
        req_fifo.push_back(make_req(MODE_SUB, 16'hffff, 64'd5, 0, 0));
        req_fifo.push_back(make_req(MODE_QUERY, 0, 0, 32'd0, 0));
        req_fifo.push_back(make_req(MODE_QUERY, 0, 0, 32'd16711680, 0));
        req_fifo.push_back(make_req(MODE_QUERY, 0, 0, 32'hffff_ffff, 0));
        req_fifo.push_back(make_req(MODE_QUERY, 0, 0, 32'hffff_8000, 0));
        req_fifo.push_back(make_req(MODE_QUERY, 0, 0, 32'd16744448, 0));
        req_fifo.push_back(make_req(MODE_QUERY, 0, 0, 32'd16744447, 0));
        req_fifo.push_back(make_req(MODE_QUERY, 0, 0, 32'h7fff_ffff, 0));
        req_fifo.push_back(make_req(MODE_QUERY, 0, 0, 32'h8000_0000, 0));
        req_fifo.push_back(make_req(MODE_SCALE, 0, 0, 0, 64'hffff_ffff_ffff_ffff));
        req_fifo.push_back(make_req(MODE_SCALE, 0, 0, 0, 64'h7fff_ffff_ffff_ffff));
        req_fifo.push_back(make_req(MODE_QUERY, 0, 0, 32'd1114112, 0));
        req_fifo.push_back(make_req(MODE_SCALE, 0, 0, 0, 64'd0));
        req_fifo.push_back(make_req(MODE_ADD, 16'd128, 64'd3, 0, 64'h8000_0000_0000_0000));
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                // full signed range on both sides, widest source
                1: write_cfg(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                             17'd65536);
                // both ranges too narrow: identity mapping
                2: write_cfg(32'd0, 32'd0, 32'd0, 32'd0, 17'd1);
                // reversed destination: merges skipped
                3: write_cfg(32'd6553600, 32'd0, 32'd0, 32'd16711680, 17'd256);
                4: write_cfg(32'hfff6_0000, 32'd655360, 32'd0, 32'd16711680, 17'd256);
                // reversed source range
                5: write_cfg(32'd0, 32'd16711680, 32'd655360, 32'd0, 17'd300);
                6: write_cfg($urandom, $urandom, $urandom, $urandom,
                             17'($urandom_range(65536, 1)));
                7: write_cfg(32'hffff_0000 - 32'($urandom_range(1 << 20)),
                             32'($urandom_range(1 << 24)),
                             32'hfffc_0000, 32'($urandom_range(1 << 22)),
                             17'($urandom_range(512, 2)));
                default: ;
            endcase
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 64; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 64; end
                default: begin send_idle = 7; recv_stall = 7; end
            endcase
            for (int i = 0; i < PER_PHASE; i++) req_fifo.push_back(random_req());
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("histogram_bin_remap_accumulator test passed");
        else
            $display("histogram_bin_remap_accumulator test failed");
        $finish;
    end

endmodule
